[hw/rtl/b64d_pkg.sv]
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [15:0] MAX_OUTPUT_RESET = 16'hFFFF;

  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic       kept;
    logic       pad;
    logic [5:0] sextet;
  } char_class_t;

  // one queued job: a finished group or an end of string
  typedef struct packed {
    logic            eos;
    logic [2:0][7:0] bytes;
    logic [2:0]      mask;
  } op_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.kept = 1'b1;
    r.pad = (c == CHAR_PAD);
    r.sextet = SEXTET_SLASH;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.sextet = 6'(c - 8'h61) + SEXTET_LOWER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.sextet = 6'(c - 8'h30) + SEXTET_DIGIT;
    end else if (c == CHAR_PLUS) begin
      r.sextet = SEXTET_PLUS;
    end else if (c == CHAR_SLASH || c == CHAR_PAD) begin
      r.sextet = SEXTET_SLASH;
    end else begin
      r.kept = 1'b0;
    end
    return r;
  endfunction

endpackage

[hw/rtl/b64d_front.sv]
`timescale 1ns / 1ps

module b64d_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char,
  input  logic             end_of_string,
  input  logic             q_full,
  output logic             push,
  output b64d_pkg::op_t    push_data
);

  logic [1:0] fill;
  logic [5:0] s0, s1, s2;
  logic       pad2;
  logic       accept;
  logic       take_char;
  b64d_pkg::char_class_t cls;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign cls = b64d_pkg::classify(in_char);
  assign take_char = accept && !end_of_string && cls.kept;

  assign push = accept && (end_of_string || (cls.kept && fill == 2'd3));

  always_comb begin
    push_data.eos = end_of_string;
    push_data.bytes[0] = {s0, s1[5:4]};
    push_data.bytes[1] = {s1[3:0], s2[5:2]};
    push_data.bytes[2] = {s2[1:0], cls.sextet};
    if (end_of_string) begin
      // partial group flush: third byte never, second only with three chars
      push_data.mask = {1'b0, (fill == 2'd3) && !pad2, fill[1]};
    end else begin
      push_data.mask = {!cls.pad, !pad2, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
      pad2 <= 1'b0;
    end else if (accept && end_of_string) begin
      fill <= 2'd0;
      pad2 <= 1'b0;
    end else if (take_char) begin
      fill <= fill + 2'd1;
      if (fill == 2'd2) begin
        pad2 <= cls.pad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_char) begin
      case (fill)
        2'd0: s0 <= cls.sextet;
        2'd1: s1 <= cls.sextet;
        2'd2: s2 <= cls.sextet;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/b64d_queue.sv]
`timescale 1ns / 1ps

module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b64d_pkg::op_t push_data,
  output logic          full,
  input  logic          pop,
  output b64d_pkg::op_t head,
  output logic          valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  b64d_pkg::op_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] used;
  logic          do_push, do_pop;

  assign full = (used == CW'(DEPTH));
  assign valid = (used != '0);
  assign head = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + CW'(1);
      end else if (do_pop && !do_push) begin
        used <= used - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/b64d_back.sv]
`timescale 1ns / 1ps

module b64d_back #(
  parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [15:0]   cfg_data,
  input  logic          q_valid,
  input  b64d_pkg::op_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          is_data,
  output logic          run_last,
  output logic [15:0]   decoded_count,
  output logic          limit_reached
);

  localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [LW-1:0] CMAX = LW'({COUNT_BITS{1'b1}});

  logic [15:0]           max_output;
  logic [COUNT_BITS-1:0] count;
  logic                  stopped;
  logic [2:0]            done;

  logic [LW-1:0] lim_ext, lim, count_ext, cnt_inc;
  logic          stop_after;
  logic [2:0]    rem, sel, later;
  logic [7:0]    sel_byte;
  logic          out_ready, emit_data, emit_done, drop, last;

  always_comb begin
    lim_ext = LW'(max_output);
    lim = (max_output == '0 || lim_ext > CMAX) ? CMAX : lim_ext;
    count_ext = LW'(count);
    cnt_inc = (count_ext < lim) ? count_ext + LW'(1) : count_ext;
    stop_after = (cnt_inc >= lim);
  end

  always_comb begin
    rem = head.mask & ~done & {3{!stopped}};
    if (rem[0]) begin
      sel = 3'b001;
      sel_byte = head.bytes[0];
    end else if (rem[1]) begin
      sel = 3'b010;
      sel_byte = head.bytes[1];
    end else begin
      sel = 3'b100;
      sel_byte = head.bytes[2];
    end
    later = rem & ~sel;
  end

  assign out_ready = !out_valid || !out_stall;
  assign emit_data = q_valid && (rem != 3'b000) && out_ready;
  assign emit_done = q_valid && (rem == 3'b000) && head.eos && out_ready;
  // a group that arrives after the limit gives nothing
  assign drop = q_valid && (rem == 3'b000) && !head.eos;
  // an end item always closes with the completion item
  assign last = !head.eos && (stop_after || later == 3'b000);
  assign pop = (emit_data && last) || emit_done || drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output <= b64d_pkg::MAX_OUTPUT_RESET;
    end else if (cfg_write) begin
      max_output <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      stopped <= 1'b0;
      done <= 3'b000;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= emit_data || emit_done;
      end
      if (emit_data) begin
        count <= cnt_inc[COUNT_BITS-1:0];
        stopped <= stop_after;
        done <= last ? 3'b000 : (done | sel);
      end else if (emit_done) begin
        count <= '0;
        stopped <= 1'b0;
        done <= 3'b000;
      end else if (drop) begin
        done <= 3'b000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_data) begin
      out_byte <= sel_byte;
      is_data <= 1'b1;
      run_last <= last;
      decoded_count <= cnt_inc[15:0];
      limit_reached <= stop_after;
    end else if (emit_done) begin
      out_byte <= 8'h00;
      is_data <= 1'b0;
      run_last <= 1'b1;
      decoded_count <= count_ext[15:0];
      limit_reached <= stopped;
    end
  end

endmodule

[hw/rtl/base64_stream_decoder_core.sv]
`timescale 1ns / 1ps

// Streaming base64 decoder (standard alphabet). One character is taken per
// clock while in_stall is low; characters outside the alphabet are skipped,
// while '=' is kept and decodes as sextet 63. Every fourth kept character
// closes a group that goes into a small job queue, and the back end sends
// the decoded bytes out one per clock while out_stall is low, so the input
// runs at one character per cycle while the output keeps up. The queue
// (QUEUE_DEPTH jobs) absorbs output stalls; the input stalls only when it
// fills. An end_of_string item flushes a partial group and is always
// answered by a completion item (is_data low) that carries the count. Once
// the count reaches max_output (0 meaning the counter maximum), further
// bytes are dropped until the end of the string. max_output is written
// through cfg_write/cfg_data; the user must do so only while the block is
// idle, as the block itself does not enforce it.
module base64_stream_decoder_core #(
  parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        run_last,
  output logic [15:0] decoded_count,
  output logic        limit_reached
);

  logic          push, q_full, pop, q_valid;
  b64d_pkg::op_t push_data, head;

  b64d_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char(in_char),
    .end_of_string(end_of_string),
    .q_full(q_full),
    .push(push),
    .push_data(push_data)
  );

  b64d_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(q_full),
    .pop(pop),
    .head(head),
    .valid(q_valid)
  );

  b64d_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .q_valid(q_valid),
    .head(head),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .is_data(is_data),
    .run_last(run_last),
    .decoded_count(decoded_count),
    .limit_reached(limit_reached)
  );

endmodule

[hw/rtl/b64d_checker.sv]
`timescale 1ns / 1ps

module b64d_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        is_data,
  input logic        run_last,
  input logic [15:0] decoded_count,
  input logic        limit_reached
);

  // output register comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // completion item closes its run and carries no byte
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_data |-> run_last && out_byte == 8'h00)
    else $error("bad completion item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_data)
      && $stable(run_last) && $stable(decoded_count) && $stable(limit_reached))
    else $error("stalled output item changed");

endmodule

bind base64_stream_decoder_core b64d_checker u_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_byte(out_byte),
  .is_data(is_data),
  .run_last(run_last),
  .decoded_count(decoded_count),
  .limit_reached(limit_reached)
);
